// ===== rtl/core/imu_offset_calibrate_correct_assert.svh =====
// ----------------------------------------------------------------------------
// IMU offset calibration assertion macros
// Concurrent property checks on the core clock; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IMU_OFFSET_CALIBRATE_CORRECT_ASSERT_SVH
`define IMU_OFFSET_CALIBRATE_CORRECT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define IMU_OCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imu_occ: same-cycle check failed");
// next-cycle implication
`define IMU_OCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imu_occ: next-cycle check failed");
`else
`define IMU_OCC_ASSERT_IMPL(label, ante, cons)
`define IMU_OCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/imu_occ_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU offset calibration package
// Widths, constants, control structs and the axis selection function.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_occ_pkg;

	localparam int SENSOR_AXES     = 3;
	localparam int AXES_PER_SENSOR = 3;
	localparam int AXIS_COUNT      = 2 * SENSOR_AXES;
	localparam int AXIS_W          = $clog2(AXIS_COUNT);

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 32;
	localparam int OFFSET_W = SAMPLE_W + 1;
	localparam int CNT_W    = 16;
	localparam int BIT_W    = $clog2(SUM_W);
	localparam int IDX_W    = $clog2(SAMPLE_W);

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0]           CALIB_RESET = 16'd1024;
	localparam logic signed [OFFSET_W-1:0] ONE_G       = 17'sd16384;
	localparam logic [AXIS_W-1:0]          ACC_Z       = 3'd2;
	localparam logic                       REG_CALIB_SAMPLES = 1'b0;

	typedef struct packed {
		logic             load;
		logic             shift;
		logic             sub;
		logic             acc;
		logic             first;
		logic             clear;
		logic [IDX_W-1:0] idx;
	} lane_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	function automatic logic axis_active(input logic [AXIS_W-1:0] axis);
		logic [AXIS_W-1:0] k;
		k = (axis < AXIS_W'(SENSOR_AXES)) ? axis : axis - AXIS_W'(SENSOR_AXES);
		return k < AXIS_W'(AXES_PER_SENSOR);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/imu_occ_lane.sv =====
// ----------------------------------------------------------------------------
// IMU offset calibration bit-serial lane
// One axis: serial subtract of the offset and serial accumulate, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_occ_lane (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  imu_occ_pkg::lane_ctrl_t                   ctrl,
	input  logic                                      active,
	input  logic [imu_occ_pkg::SAMPLE_W-1:0]          raw_in,
	input  logic signed [imu_occ_pkg::OFFSET_W-1:0]   offset,
	output logic [imu_occ_pkg::SAMPLE_W-1:0]          diff,
	output logic signed [imu_occ_pkg::SUM_W-1:0]      sum
);

	logic [imu_occ_pkg::SAMPLE_W-1:0] raw_q;
	logic [imu_occ_pkg::SAMPLE_W-1:0] diff_q;
	logic [imu_occ_pkg::SUM_W-1:0]    sum_q;
	logic [imu_occ_pkg::SAMPLE_W-1:0] off_lo;
	logic sub_c_q;
	logic add_c_q;
	logic obit;
	logic cs_in;
	logic ca_in;
	logic d_bit;
	logic cs_out;
	logic s_bit;
	logic ca_out;
	logic acc_en;

	assign off_lo = offset[imu_occ_pkg::SAMPLE_W-1:0];
	assign obit   = off_lo[ctrl.idx];
	assign cs_in  = ctrl.first ? 1'b1 : sub_c_q;
	assign ca_in  = ctrl.first ? 1'b0 : add_c_q;

	// raw + ~offset + 1, one bit a cycle
	assign d_bit  = raw_q[0] ^ ~obit ^ cs_in;
	assign cs_out = (raw_q[0] & ~obit) | (raw_q[0] & cs_in) | (~obit & cs_in);

	assign s_bit  = sum_q[0] ^ raw_q[0] ^ ca_in;
	assign ca_out = (sum_q[0] & raw_q[0]) | (sum_q[0] & ca_in) | (raw_q[0] & ca_in);

	assign acc_en = ctrl.shift & ctrl.acc & active;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			raw_q <= raw_in;
		end else if (ctrl.shift) begin
			// arithmetic shift supplies the sign extension for the sum
			raw_q <= {raw_q[imu_occ_pkg::SAMPLE_W-1], raw_q[imu_occ_pkg::SAMPLE_W-1:1]};
		end
		if (ctrl.shift && ctrl.sub) begin
			diff_q  <= {d_bit, diff_q[imu_occ_pkg::SAMPLE_W-1:1]};
			sub_c_q <= cs_out;
		end
		if (acc_en) begin
			add_c_q <= ca_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (acc_en) begin
			// rotate: after a full pass the register holds the new sum
			sum_q <= {s_bit, sum_q[imu_occ_pkg::SUM_W-1:1]};
		end
	end

	assign diff = diff_q;
	assign sum  = $signed(sum_q);

endmodule

`default_nettype wire

// ===== rtl/core/imu_occ_div.sv =====
// ----------------------------------------------------------------------------
// IMU offset calibration serial divider
// Restoring signed division, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_occ_div (
	input  logic                                     clk,
	input  imu_occ_pkg::div_ctrl_t                   ctrl,
	input  logic signed [imu_occ_pkg::SUM_W-1:0]     dividend,
	input  logic [imu_occ_pkg::CNT_W-1:0]            divisor,
	output logic signed [imu_occ_pkg::OFFSET_W-1:0]  quotient
);

	logic [imu_occ_pkg::SUM_W-1:0]    dq_q;
	logic [imu_occ_pkg::CNT_W-1:0]    rem_q;
	logic                             neg_q;
	logic [imu_occ_pkg::SUM_W-1:0]    mag;
	logic [imu_occ_pkg::CNT_W:0]      trial;
	logic [imu_occ_pkg::CNT_W:0]      diff;
	logic                             qbit;
	logic [imu_occ_pkg::OFFSET_W-1:0] q_lo;

	assign mag   = dividend[imu_occ_pkg::SUM_W-1] ? (imu_occ_pkg::SUM_W'(0) - dividend)
		: dividend;
	assign trial = {rem_q, dq_q[imu_occ_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dq_q  <= mag;
			rem_q <= '0;
			neg_q <= dividend[imu_occ_pkg::SUM_W-1];
		end else if (ctrl.step) begin
			rem_q <= qbit ? diff[imu_occ_pkg::CNT_W-1:0] : trial[imu_occ_pkg::CNT_W-1:0];
			dq_q  <= {dq_q[imu_occ_pkg::SUM_W-2:0], qbit};
		end
	end

	// magnitude of an average of 16-bit words fits 17 bits
	assign q_lo     = dq_q[imu_occ_pkg::OFFSET_W-1:0];
	assign quotient = $signed(neg_q ? (imu_occ_pkg::OFFSET_W'(0) - q_lo) : q_lo);

endmodule

`default_nettype wire

// ===== rtl/core/imu_offset_calibrate_correct.sv =====
// Each accepted word shifts bit-serially through the lanes, then waits for the output register.
// The word that completes a run first passes each axis in turn through the serial divider.
// Throughput: one word in flight; the next is taken the cycle after its result is registered.
// The add/subtract lanes move one bit per cycle; the shared divider one quotient bit per cycle.
// Reset clears offsets, sums and the sample count, and sets calib_samples to 1024.
// ----------------------------------------------------------------------------
// IMU offset calibration and correction
// Corrects six-axis samples by stored offsets and averages calibration runs.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_offset_calibrate_correct (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [imu_occ_pkg::ADDR_W-1:0]           paddr,
	input  logic [imu_occ_pkg::DATA_W-1:0]           pwdata,
	output logic [imu_occ_pkg::DATA_W-1:0]           prdata,
	output logic                                     pready,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     command,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_x_raw,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_y_raw,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_z_raw,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_x_raw,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_y_raw,
	input  logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_z_raw,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_x_out,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_y_out,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  accel_z_out,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_x_out,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_y_out,
	output logic signed [imu_occ_pkg::SAMPLE_W-1:0]  gyro_z_out,
	output logic                                     calib_finished
);

`include "imu_offset_calibrate_correct_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DLOAD,
		ST_DSTEP,
		ST_DWRITE,
		ST_HOLD
	} state_t;

	state_t                                  state_q;
	logic [imu_occ_pkg::BIT_W-1:0]           bit_q;
	logic [imu_occ_pkg::AXIS_W-1:0]          axis_q;
	logic                                    cmd_q;
	logic                                    finish_q;
	logic [imu_occ_pkg::CNT_W-1:0]           taken_q;
	logic [imu_occ_pkg::CNT_W-1:0]           samples_q;
	logic [imu_occ_pkg::CNT_W-1:0]           calib_q;
	logic signed [imu_occ_pkg::OFFSET_W-1:0] offset_q [imu_occ_pkg::AXIS_COUNT];
	logic [imu_occ_pkg::SAMPLE_W-1:0]        out_q [imu_occ_pkg::AXIS_COUNT];
	logic                                    out_valid_q;
	logic                                    out_fin_q;

	logic [imu_occ_pkg::SAMPLE_W-1:0]        raw_w  [imu_occ_pkg::AXIS_COUNT];
	logic [imu_occ_pkg::SAMPLE_W-1:0]        diff_w [imu_occ_pkg::AXIS_COUNT];
	logic signed [imu_occ_pkg::SUM_W-1:0]    sum_w  [imu_occ_pkg::AXIS_COUNT];

	imu_occ_pkg::lane_ctrl_t                 lane_ctrl;
	imu_occ_pkg::div_ctrl_t                  div_ctrl;
	logic signed [imu_occ_pkg::OFFSET_W-1:0] div_quot;
	logic signed [imu_occ_pkg::OFFSET_W-1:0] new_off;

	logic                                    in_accept;
	logic                                    cfg_write;
	logic                                    out_load;
	logic                                    shift_last;
	logic [imu_occ_pkg::CNT_W-1:0]           target;
	logic [imu_occ_pkg::CNT_W:0]             taken_w;
	logic                                    finish_w;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= imu_occ_pkg::CALIB_RESET;
		end else if (cfg_write && paddr[2] == imu_occ_pkg::REG_CALIB_SAMPLES) begin
			calib_q <= pwdata[imu_occ_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == imu_occ_pkg::REG_CALIB_SAMPLES) begin
			prdata = imu_occ_pkg::DATA_W'(calib_q);
		end
	end

	// ------------------------------------------------------------------
	// control
	// ------------------------------------------------------------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);

	// a count of zero behaves as one
	assign target   = (calib_q == '0) ? imu_occ_pkg::CNT_W'(1) : calib_q;
	assign taken_w  = {1'b0, samples_q} + (imu_occ_pkg::CNT_W + 1)'(1);
	assign finish_w = (taken_w >= {1'b0, target});

	assign shift_last = cmd_q ? (bit_q == imu_occ_pkg::BIT_W'(imu_occ_pkg::SUM_W - 1))
		: (bit_q == imu_occ_pkg::BIT_W'(imu_occ_pkg::SAMPLE_W - 1));

	always_comb begin
		lane_ctrl.load  = in_accept;
		lane_ctrl.shift = (state_q == ST_SHIFT);
		lane_ctrl.sub   = (bit_q < imu_occ_pkg::BIT_W'(imu_occ_pkg::SAMPLE_W));
		lane_ctrl.acc   = cmd_q;
		lane_ctrl.first = (bit_q == '0);
		lane_ctrl.clear = (state_q == ST_DWRITE)
			&& (axis_q == imu_occ_pkg::AXIS_W'(imu_occ_pkg::AXIS_COUNT - 1));
		lane_ctrl.idx   = bit_q[imu_occ_pkg::IDX_W-1:0];
		div_ctrl.load   = (state_q == ST_DLOAD);
		div_ctrl.step   = (state_q == ST_DSTEP);
	end

	assign new_off = (axis_q == imu_occ_pkg::ACC_Z) ? (div_quot - imu_occ_pkg::ONE_G) : div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			axis_q      <= '0;
			cmd_q       <= 1'b0;
			finish_q    <= 1'b0;
			taken_q     <= '0;
			samples_q   <= '0;
			out_valid_q <= 1'b0;
			out_fin_q   <= 1'b0;
			for (int a = 0; a < imu_occ_pkg::AXIS_COUNT; a++) begin
				offset_q[a] <= '0;
				out_q[a]    <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						cmd_q    <= command;
						finish_q <= command & finish_w;
						taken_q  <= taken_w[imu_occ_pkg::CNT_W-1:0];
						bit_q    <= '0;
						if (command) begin
							samples_q <= finish_w ? '0 : taken_w[imu_occ_pkg::CNT_W-1:0];
						end
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					bit_q <= bit_q + imu_occ_pkg::BIT_W'(1);
					if (shift_last) begin
						axis_q  <= '0;
						state_q <= finish_q ? ST_DLOAD : ST_HOLD;
					end
				end
				ST_DLOAD: begin
					bit_q   <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					bit_q <= bit_q + imu_occ_pkg::BIT_W'(1);
					if (bit_q == imu_occ_pkg::BIT_W'(imu_occ_pkg::SUM_W - 1)) begin
						state_q <= ST_DWRITE;
					end
				end
				ST_DWRITE: begin
					if (imu_occ_pkg::axis_active(axis_q)) begin
						offset_q[axis_q] <= new_off;
					end
					if (axis_q == imu_occ_pkg::AXIS_W'(imu_occ_pkg::AXIS_COUNT - 1)) begin
						state_q <= ST_HOLD;
					end else begin
						axis_q  <= axis_q + imu_occ_pkg::AXIS_W'(1);
						state_q <= ST_DLOAD;
					end
				end
				ST_HOLD: begin
					// wait for the output register to free up
					if (out_load) begin
						for (int a = 0; a < imu_occ_pkg::AXIS_COUNT; a++) begin
							out_q[a] <= diff_w[a];
						end
						out_fin_q   <= finish_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	always_comb begin
		raw_w[0] = accel_x_raw;
		raw_w[1] = accel_y_raw;
		raw_w[2] = accel_z_raw;
		raw_w[3] = gyro_x_raw;
		raw_w[4] = gyro_y_raw;
		raw_w[5] = gyro_z_raw;
	end

	for (genvar g = 0; g < imu_occ_pkg::AXIS_COUNT; g++) begin : g_lane
		imu_occ_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.active (imu_occ_pkg::axis_active(imu_occ_pkg::AXIS_W'(g))),
			.raw_in (raw_w[g]),
			.offset (offset_q[g]),
			.diff   (diff_w[g]),
			.sum    (sum_w[g])
		);
	end

	imu_occ_div u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (sum_w[axis_q]),
		.divisor  (taken_q),
		.quotient (div_quot)
	);

	assign out_valid      = out_valid_q;
	assign accel_x_out    = $signed(out_q[0]);
	assign accel_y_out    = $signed(out_q[1]);
	assign accel_z_out    = $signed(out_q[2]);
	assign gyro_x_out     = $signed(out_q[3]);
	assign gyro_y_out     = $signed(out_q[4]);
	assign gyro_z_out     = $signed(out_q[5]);
	assign calib_finished = out_fin_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`IMU_OCC_ASSERT_NEXT(a_accept_starts_shift, in_accept, state_q == ST_SHIFT)
	`IMU_OCC_ASSERT_IMPL(a_div_needs_finish, state_q == ST_DLOAD || state_q == ST_DSTEP || state_q == ST_DWRITE, finish_q && cmd_q)
	`IMU_OCC_ASSERT_IMPL(a_count_below_max, 1'b1, samples_q != '1)
	`IMU_OCC_ASSERT_NEXT(a_finish_reported, out_load && finish_q, out_valid && calib_finished)

endmodule

`default_nettype wire
